@@ design/cts_pkg.sv @@
// Types, codes and classification functions for the C-style token scanner.
// Used by every module of the block.
package cts_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 12;
    localparam int OFFSET_BITS = 24;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [6:0]             token_kind;
        logic [2:0]             error_code;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [11:0]            token_length;
        logic                   last_of_run;
    } out_item_t;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_ZERO, M_DEC, M_OCT, M_HEX, M_BIN, M_FLOAT,
        M_CHR, M_CHR_ESC, M_STR, M_STR_ESC, M_OP, M_LCOM, M_BCOM, M_BSTAR, M_DONE
    } mode_t;

    localparam logic [6:0] K_END     = 7'd0;
    localparam logic [6:0] K_IDENT   = 7'd1;
    localparam logic [6:0] K_KEY0    = 7'd2;
    localparam logic [6:0] K_DEC     = 7'd25;
    localparam logic [6:0] K_OCT     = 7'd26;
    localparam logic [6:0] K_HEX     = 7'd27;
    localparam logic [6:0] K_BIN     = 7'd28;
    localparam logic [6:0] K_FLOAT   = 7'd29;
    localparam logic [6:0] K_CHAR    = 7'd30;
    localparam logic [6:0] K_STRING  = 7'd31;
    localparam logic [6:0] K_OP0     = 7'd32;
    localparam logic [6:0] K_PUNCT0  = 7'd66;
    localparam logic [6:0] K_INVALID = 7'd76;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_DIGIT   = 3'd1;
    localparam logic [2:0] E_UNTERM  = 3'd2;
    localparam logic [2:0] E_COMMENT = 3'd3;
    localparam logic [2:0] E_CHAR    = 3'd4;

    localparam int KW_COUNT = 23;
    localparam int KW_MAXLEN = 8;
    localparam int LEN_BITS = 12;

    // Keyword spellings, first byte in the low byte, zero padded.
    typedef logic [8*KW_MAXLEN-1:0] kw_word_t;
    localparam kw_word_t KW_TAB [KW_COUNT] = '{
        64'h00000000006d7361, 64'h0000006b61657262, 64'h0000000072616863,
        64'h00000074736e6f63, 64'h65756e69746e6f63, 64'h0000000000006f64,
        64'h0000656c62756f64, 64'h0000000065736c65, 64'h00006e7265747865,
        64'h00000074616f6c66, 64'h0000000000726f66, 64'h00006c61626f6c67,
        64'h000000006f746f67, 64'h0000000000006669,
        64'h0000000000746e69, 64'h00000000676e6f6c, 64'h000064726f636572,
        64'h00006e7275746572, 64'h00000074726f6873, 64'h0000666f657a6973,
        64'h0000636974617473, 64'h0000000064696f76, 64'h000000656c696877
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd4, 4'd5, 4'd8, 4'd2, 4'd6, 4'd4, 4'd6, 4'd5, 4'd3, 4'd6,
        4'd4, 4'd2, 4'd3, 4'd4, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd4, 4'd5
    };

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)
            || c == 8'h5f || c == 8'h24;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hexd(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a;
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        logic r;
        r = is_space(c);
        case (c)
            8'h21, 8'h25, 8'h5e, 8'h7e, 8'h26, 8'h2a, 8'h28, 8'h29, 8'h2d, 8'h2b,
            8'h3d, 8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h7c, 8'h3a, 8'h3b, 8'h3c, 8'h3e,
            8'h2c, 8'h2e, 8'h2f, 8'h5c, 8'h27, 8'h22, 8'h40, 8'h23, 8'h60,
            8'h3f: r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    // Operator index of a 1..3 byte sequence (zero bytes pad); found is cleared and index 0 returned if none.
    function automatic logic [5:0] op_index(input logic [23:0] s, output logic found);
        logic [5:0] k;
        found = 1'b1;
        k = 6'd0;
        case (s)
            24'h00002b: k = 6'd0;  24'h003d2b: k = 6'd1;  24'h002b2b: k = 6'd2;
            24'h00002d: k = 6'd3;  24'h003d2d: k = 6'd4;  24'h002d2d: k = 6'd5;
            24'h003e2d: k = 6'd6;  24'h00002a: k = 6'd7;  24'h003d2a: k = 6'd8;
            24'h00002f: k = 6'd9;  24'h003d2f: k = 6'd10; 24'h000025: k = 6'd11;
            24'h003d25: k = 6'd12; 24'h000026: k = 6'd13; 24'h003d26: k = 6'd14;
            24'h002626: k = 6'd15; 24'h00007c: k = 6'd16; 24'h003d7c: k = 6'd17;
            24'h007c7c: k = 6'd18; 24'h000021: k = 6'd19; 24'h003d21: k = 6'd20;
            24'h00007e: k = 6'd21; 24'h00003c: k = 6'd22; 24'h003d3c: k = 6'd23;
            24'h003c3c: k = 6'd24; 24'h3d3c3c: k = 6'd25; 24'h00003e: k = 6'd26;
            24'h003d3e: k = 6'd27; 24'h003e3e: k = 6'd28; 24'h3d3e3e: k = 6'd29;
            24'h00005e: k = 6'd30; 24'h003d5e: k = 6'd31; 24'h00003d: k = 6'd32;
            24'h003d3d: k = 6'd33;
            default: found = 1'b0;
        endcase
        return k;
    endfunction

    // Prefixes that some longer operator extends.
    function automatic logic op_extends(input logic [23:0] s);
        logic r;
        case (s)
            24'h00002b, 24'h00002d, 24'h00002a, 24'h00002f, 24'h000025, 24'h000026,
            24'h00007c, 24'h000021, 24'h00003c, 24'h003c3c, 24'h00003e, 24'h003e3e,
            24'h00005e, 24'h00003d: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] punct_index(input logic [7:0] c, output logic found);
        logic [3:0] k;
        found = 1'b1;
        k = 4'd0;
        case (c)
            8'h2e: k = 4'd0; 8'h2c: k = 4'd1; 8'h3a: k = 4'd2; 8'h7b: k = 4'd3;
            8'h7d: k = 4'd4; 8'h28: k = 4'd5; 8'h29: k = 4'd6; 8'h5b: k = 4'd7;
            8'h5d: k = 4'd8; 8'h3b: k = 4'd9;
            default: found = 1'b0;
        endcase
        return k;
    endfunction

endpackage

@@ design/cts_scan_core.sv @@
// Per-byte scanner: mode update, position counters and event generation.
// Depends on cts_pkg.
module cts_scan_core
    import cts_pkg::*;
#(
    parameter int KEYWORD_CHARS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  in_item_t        item,
    output logic [1:0]      ev_count,
    output out_item_t       ev [3]
);

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LEN_BITS-1:0]    LEN_MAX  = '1;

    mode_t                   mode_reg, mode_next;
    logic [15:0]             held_reg, held_next;
    logic [7:0]              kw_reg [KEYWORD_CHARS];
    logic [7:0]              kw_next [KEYWORD_CHARS];
    logic [LEN_BITS-1:0]     len_reg, len_next;
    logic [LINE_BITS-1:0]    sline_reg, sline_next, line_reg, line_next;
    logic [COLUMN_BITS-1:0]  scol_reg, scol_next, col_reg, col_next;
    logic [OFFSET_BITS-1:0]  soff_reg, soff_next, off_reg, off_next;
    logic [2:0]              perr_reg, perr_next;

    function automatic logic [6:0] ident_kind(input logic [LEN_BITS-1:0] n,
                                              input logic [7:0] w [KEYWORD_CHARS]);
        logic [6:0] k;
        logic ok;
        k = K_IDENT;
        if (n <= LEN_BITS'(KEYWORD_CHARS) && n <= LEN_BITS'(KW_MAXLEN)) begin
            for (int i = KW_COUNT - 1; i >= 0; i--) begin
                ok = (LEN_BITS'(KW_LEN[i]) == n);
                for (int j = 0; j < KW_MAXLEN; j++) begin
                    if (j < KEYWORD_CHARS && LEN_BITS'(j) < n
                        && KW_TAB[i][8*j +: 8] != w[j])
                        ok = 1'b0;
                end
                if (ok)
                    k = K_KEY0 + 7'(i);
            end
        end
        return k;
    endfunction

    always_comb
    begin
        logic [7:0] c;
        logic absorbed, fnd, f2, is_slash, endit;
        logic [23:0] s;
        logic [5:0] k;
        logic [3:0] pk;
        logic [6:0] fk;
        logic [2:0] fe;
        logic       femit;
        mode_t m;
        logic [1:0] n;
        logic       ok;
        out_item_t e;

        c = item.char_code;
        mode_next = mode_reg;
        held_next = held_reg;
        kw_next = kw_reg;
        len_next = len_reg;
        sline_next = sline_reg;
        scol_next = scol_reg;
        soff_next = soff_reg;
        line_next = line_reg;
        col_next = col_reg;
        off_next = off_reg;
        perr_next = perr_reg;
        n = 2'd0;
        ev = '{default: '0};
        absorbed = 1'b0;
        e = '0;
        m = mode_reg;
        femit = 1'b0;
        fe = E_NONE;
        fk = K_INVALID;
        s = '0;
        k = '0;
        fnd = 1'b0;
        f2 = 1'b0;
        pk = '0;
        is_slash = 1'b0;
        ok = 1'b0;
        endit = (c == 8'd0) || item.end_of_text;

        if (mode_reg != M_DONE && c != 8'd0) begin
            m = mode_reg;
            // offer byte to pending token
            unique case (m)
                M_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        absorbed = 1'b1;
                        for (int j = 0; j < KEYWORD_CHARS; j++)
                            if (len_reg == LEN_BITS'(j)) kw_next[j] = c;
                    end
                end
                M_ZERO, M_DEC, M_OCT, M_HEX, M_BIN, M_FLOAT: begin
                    if (c == 8'h2e && perr_reg == E_NONE && (m == M_ZERO || m == M_DEC)) begin
                        absorbed = 1'b1;
                        mode_next = M_FLOAT;
                    end else if (!is_term(c)) begin
                        absorbed = 1'b1;
                        if (perr_reg == E_NONE) begin
                            ok = is_digit(c);
                            if (m == M_ZERO) begin
                                if (c == 8'h78 || c == 8'h58) begin
                                    mode_next = M_HEX; ok = 1'b1;
                                end else if (c == 8'h62 || c == 8'h42) begin
                                    mode_next = M_BIN; ok = 1'b1;
                                end else begin
                                    mode_next = M_OCT;
                                    ok = c >= 8'h30 && c <= 8'h37;
                                end
                            end else if (m == M_OCT) ok = c >= 8'h30 && c <= 8'h37;
                            else if (m == M_HEX) ok = is_hexd(c);
                            else if (m == M_BIN) ok = c == 8'h30 || c == 8'h31;
                            if (!ok) perr_next = E_DIGIT;
                        end
                    end
                end
                M_CHR, M_STR: begin
                    if (c != 8'h0a) begin
                        absorbed = 1'b1;
                        if (c == 8'h5c)
                            mode_next = (m == M_CHR) ? M_CHR_ESC : M_STR_ESC;
                        else if (c == ((m == M_CHR) ? 8'h27 : 8'h22)) begin
                            e.token_kind = (m == M_CHR) ? K_CHAR : K_STRING;
                            e.error_code = E_NONE;
                            ev[n] = e; n = n + 2'd1;
                            mode_next = M_IDLE;
                        end
                    end
                end
                M_CHR_ESC, M_STR_ESC: begin
                    if (c != 8'h0a) begin
                        absorbed = 1'b1;
                        mode_next = (m == M_CHR_ESC) ? M_CHR : M_STR;
                    end
                end
                M_OP: begin
                    is_slash = held_reg == 16'h002f;
                    if (is_slash && (c == 8'h2f || c == 8'h2a)) begin
                        absorbed = 1'b1;
                        mode_next = (c == 8'h2f) ? M_LCOM : M_BCOM;
                        held_next = '0;
                    end else begin
                        s = (held_reg[15:8] != 8'd0) ? {c, held_reg} : {8'd0, c, held_reg[7:0]};
                        k = op_index(s, fnd);
                        if (fnd) begin
                            absorbed = 1'b1;
                            if (op_extends(s))
                                held_next = {c, held_reg[7:0]};
                            else begin
                                e.token_kind = K_OP0 + 7'(k);
                                ev[n] = e; n = n + 2'd1;
                                mode_next = M_IDLE;
                                held_next = '0;
                            end
                        end
                    end
                end
                M_LCOM: absorbed = (c != 8'h0a);
                M_BCOM, M_BSTAR: begin
                    absorbed = 1'b1;
                    if (c == 8'h2a) mode_next = M_BSTAR;
                    else if (c == 8'h2f && m == M_BSTAR) mode_next = M_IDLE;
                    else mode_next = M_BCOM;
                end
                default: ;
            endcase

            if (absorbed) begin
                len_next = (len_reg == LEN_MAX) ? LEN_MAX : len_reg + 1'b1;
                // length in emitted event includes this byte
                for (int i = 0; i < 3; i++) ev[i].token_length = len_next;
            end else begin
                // flush pending token
                femit = 1'b1;
                fe = E_NONE;
                fk = K_INVALID;
                unique case (m)
                    M_IDENT: fk = ident_kind(len_reg, kw_reg);
                    M_ZERO, M_OCT: begin fk = K_OCT; fe = perr_reg; end
                    M_DEC: begin fk = K_DEC; fe = perr_reg; end
                    M_HEX: begin fk = K_HEX; fe = perr_reg; end
                    M_BIN: begin fk = K_BIN; fe = perr_reg; end
                    M_FLOAT: begin fk = K_FLOAT; fe = perr_reg; end
                    M_CHR, M_CHR_ESC: begin fk = K_CHAR; fe = E_UNTERM; end
                    M_STR, M_STR_ESC: begin fk = K_STRING; fe = E_UNTERM; end
                    M_OP: begin
                        k = op_index({8'd0, held_reg}, fnd);
                        fk = fnd ? K_OP0 + 7'(k) : K_INVALID;
                    end
                    M_BCOM, M_BSTAR: begin fk = K_INVALID; fe = E_COMMENT; end
                    default: femit = 1'b0;
                endcase
                if (femit) begin
                    e = '0;
                    e.token_kind = fk;
                    e.error_code = fe;
                    e.token_length = len_reg;
                    ev[n] = e; n = n + 2'd1;
                end
                mode_next = M_IDLE;
                held_next = '0;
                perr_next = E_NONE;
                // scan byte afresh from idle
                if (!is_space(c)) begin
                    sline_next = line_reg;
                    scol_next = col_reg;
                    soff_next = off_reg;
                    len_next = LEN_BITS'(1);
                    e = '0;
                    e.token_length = LEN_BITS'(1);
                    e.start_line = sline_next;
                    e.start_column = scol_next;
                    e.start_offset = soff_next;
                    k = op_index({16'd0, c}, fnd);
                    pk = punct_index(c, f2);
                    if (is_letter(c)) begin
                        mode_next = M_IDENT;
                        for (int j = 0; j < KEYWORD_CHARS; j++) kw_next[j] = '0;
                        kw_next[0] = c;
                    end else if (c == 8'h30) mode_next = M_ZERO;
                    else if (is_digit(c)) mode_next = M_DEC;
                    else if (c == 8'h27) mode_next = M_CHR;
                    else if (c == 8'h22) mode_next = M_STR;
                    else if (fnd) begin
                        if (op_extends({16'd0, c})) begin
                            mode_next = M_OP;
                            held_next = {8'd0, c};
                        end else begin
                            e.token_kind = K_OP0 + 7'(k);
                            ev[n] = e; n = n + 2'd1;
                        end
                    end else if (f2) begin
                        e.token_kind = K_PUNCT0 + 7'(pk);
                        ev[n] = e; n = n + 2'd1;
                    end else begin
                        e.token_kind = K_INVALID;
                        e.error_code = E_CHAR;
                        ev[n] = e; n = n + 2'd1;
                    end
                end
            end

            // start fields of events drawn from token start registers, except a token opened and closed by this byte
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n && !(!absorbed && !is_space(c) && 2'(i) == n - 2'd1
                    && mode_next == M_IDLE && ev[i].token_length == LEN_BITS'(1)
                    && !(i == 0 && femit))) begin
                    ev[i].start_line = sline_reg;
                    ev[i].start_column = scol_reg;
                    ev[i].start_offset = soff_reg;
                end
            end

            off_next = (off_reg == OFF_MAX) ? OFF_MAX : off_reg + 1'b1;
            if (c == 8'h0a) begin
                line_next = (line_reg == LINE_MAX) ? LINE_MAX : line_reg + 1'b1;
                col_next = COLUMN_BITS'(1);
            end else
                col_next = (col_reg == COL_MAX) ? COL_MAX : col_reg + 1'b1;
        end

        if (mode_reg != M_DONE && endit) begin
            m = (c == 8'd0) ? mode_reg : mode_next;
            femit = 1'b1;
            fe = E_NONE;
            fk = K_INVALID;
            unique case (m)
                M_IDENT: fk = ident_kind(len_next, kw_next);
                M_ZERO, M_OCT: begin fk = K_OCT; fe = perr_next; end
                M_DEC: begin fk = K_DEC; fe = perr_next; end
                M_HEX: begin fk = K_HEX; fe = perr_next; end
                M_BIN: begin fk = K_BIN; fe = perr_next; end
                M_FLOAT: begin fk = K_FLOAT; fe = perr_next; end
                M_CHR, M_CHR_ESC: begin fk = K_CHAR; fe = E_UNTERM; end
                M_STR, M_STR_ESC: begin fk = K_STRING; fe = E_UNTERM; end
                M_OP: begin
                    k = op_index({8'd0, held_next}, fnd);
                    fk = fnd ? K_OP0 + 7'(k) : K_INVALID;
                end
                M_BCOM, M_BSTAR: begin fk = K_INVALID; fe = E_COMMENT; end
                default: femit = 1'b0;
            endcase
            if (femit) begin
                e = '0;
                e.token_kind = fk;
                e.error_code = fe;
                e.start_line = sline_next;
                e.start_column = scol_next;
                e.start_offset = soff_next;
                e.token_length = len_next;
                ev[n] = e; n = n + 2'd1;
            end
            e = '0;
            e.token_kind = K_END;
            e.start_line = line_next;
            e.start_column = col_next;
            e.start_offset = off_next;
            ev[n] = e; n = n + 2'd1;
            mode_next = M_DONE;
            held_next = '0;
            perr_next = E_NONE;
        end

        for (int i = 0; i < 3; i++)
            ev[i].last_of_run = (2'(i) == n - 2'd1) && n != 2'd0;
        ev_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            held_reg <= '0;
            kw_reg <= '{default: '0};
            len_reg <= '0;
            sline_reg <= LINE_BITS'(1);
            scol_reg <= COLUMN_BITS'(1);
            soff_reg <= '0;
            line_reg <= LINE_BITS'(1);
            col_reg <= COLUMN_BITS'(1);
            off_reg <= '0;
            perr_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            kw_reg <= kw_next;
            len_reg <= len_next;
            sline_reg <= sline_next;
            scol_reg <= scol_next;
            soff_reg <= soff_next;
            line_reg <= line_next;
            col_reg <= col_next;
            off_reg <= off_next;
            perr_reg <= perr_next;
        end
    end

endmodule

@@ design/cts_out_queue.sv @@
// Result queue: takes up to three events per byte, delivers one per cycle while out_ready is high.
// Depends on cts_pkg.
module cts_out_queue
    import cts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [1:0]  push_count,
    input  out_item_t   push_items [3],
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    localparam int DEPTH = 8;

    out_item_t   mem_reg [DEPTH];
    logic [2:0]  rd_reg, wr_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic        pop;

    assign out_valid = cnt_reg != 4'd0;
    assign out_item  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // leave space for a full run of three events
    assign room      = cnt_reg <= 4'(DEPTH - 3);

    always_comb
    begin
        cnt_next = cnt_reg + (push ? {2'b00, push_count} : 4'd0) - {3'd0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            for (int i = 0; i < 3; i++)
                if (2'(i) < push_count)
                    mem_reg[3'(wr_reg + 3'(i))] <= push_items[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (pop) rd_reg <= rd_reg + 3'd1;
            if (push) wr_reg <= wr_reg + {1'b0, push_count};
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ design/c_style_token_scanner.sv @@
// C-style token scanner: one source byte per cycle in, token events out.
// Each event is registered in the result queue before it is offered.
// Throughput: one byte per cycle; the eight-entry result queue stalls input
// while fewer than three slots are free.
// Reset: asynchronous active low; scanner idle at line 1, column 1, offset 0.
module c_style_token_scanner
    import cts_pkg::*;
#(
    parameter int KEYWORD_CHARS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic       step;
    logic [1:0] ev_count;
    out_item_t  ev [3];

    assign step = in_valid && in_ready;

    cts_scan_core #(
        .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_core (
        .clk(clk), .rst_n(rst_n), .step(step), .item(in_data),
        .ev_count(ev_count), .ev(ev)
    );

    cts_out_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(step), .push_count(ev_count),
        .push_items(ev), .room(in_ready), .out_valid(out_valid),
        .out_ready(out_ready), .out_item(out_data)
    );

    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> !step)
        else $error("byte accepted without queue room");
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty queue");

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for c_style_token_scanner: a directed source text, then
// random C-like text, checked event by event against an in-bench scanner model.
// Depends on cts_pkg for the payload structs, scan modes and kind/error codes.
module tb_top;
    import cts_pkg::*;

    localparam int LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0] ch;
        bit         chk;
        logic [6:0] kind;
        logic [2:0] err;
    } row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    c_style_token_scanner DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #5 clk = ~clk;

    // Scanner model state
    mode_t       sc_mode;
    string       sc_held;
    string       sc_kw;
    logic [11:0] sc_len;
    logic [15:0] sc_tline, sc_line;
    logic [11:0] sc_tcol, sc_col;
    logic [23:0] sc_toff, sc_off;
    logic [2:0]  sc_perr;

    out_item_t token_q[$];
    out_item_t step_events[$];
    int        errors = 0;
    int        cycles = 0;
    int        bytes_sent = 0;
    int        events_seen = 0;
    bit        stim_done = 0;
    bit        hold_req = 0;

    string kw_names[23] = '{"asm", "break", "char", "const", "continue", "do", "double",
        "else", "extern", "float", "for", "global", "goto", "if", "int", "long", "record",
        "return", "short", "sizeof", "static", "void", "while"};
    string op_names[34] = '{"+", "+=", "++", "-", "-=", "--", "->", "*", "*=", "/", "/=",
        "%", "%=", "&", "&=", "&&", "|", "|=", "||", "!", "!=", "~", "<", "<=", "<<",
        "<<=", ">", ">=", ">>", ">>=", "^", "^=", "=", "=="};
    string punct_chars = ".,:{}()[];";
    string stop_chars = "!%^~&*()-+=[]{}|:;<>,./\\'\"@#`?";

    function automatic bit letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit blank(logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0a;
    endfunction

    function automatic bit ends_number(logic [7:0] c);
        if (blank(c)) return 1;
        for (int i = 0; i < stop_chars.len(); i++) if (stop_chars[i] == c) return 1;
        return 0;
    endfunction

    function automatic int op_lookup(string s);
        foreach (op_names[i]) if (op_names[i] == s) return i;
        return -1;
    endfunction

    function automatic bit op_grows(string s);
        foreach (op_names[i])
            if (op_names[i].len() > s.len() && op_names[i].substr(0, s.len() - 1) == s)
                return 1;
        return 0;
    endfunction

    function automatic void add_event(logic [6:0] k, logic [2:0] e, logic [15:0] l,
                                      logic [11:0] c, logic [23:0] o, logic [11:0] n);
        out_item_t ev;
        if (step_events.size() >= 3) return;
        ev = '{k, e, l, c, o, n, 1'b0};
        step_events = {step_events, ev};
    endfunction

    function automatic void close_token(logic [6:0] k, logic [2:0] e);
        add_event(k, e, sc_tline, sc_tcol, sc_toff, sc_len);
    endfunction

    function automatic void grow_len();
        if (sc_len != 12'hfff) sc_len = sc_len + 12'd1;
    endfunction

    function automatic logic [6:0] word_kind();
        if (sc_len > 8) return K_IDENT;
        foreach (kw_names[i]) if (kw_names[i] == sc_kw) return K_KEY0 + 7'(i);
        return K_IDENT;
    endfunction

    function automatic void flush_token();
        int k;
        case (sc_mode)
            M_IDENT: close_token(word_kind(), E_NONE);
            M_ZERO, M_OCT: close_token(K_OCT, sc_perr);
            M_DEC: close_token(K_DEC, sc_perr);
            M_HEX: close_token(K_HEX, sc_perr);
            M_BIN: close_token(K_BIN, sc_perr);
            M_FLOAT: close_token(K_FLOAT, sc_perr);
            M_CHR, M_CHR_ESC: close_token(K_CHAR, E_UNTERM);
            M_STR, M_STR_ESC: close_token(K_STRING, E_UNTERM);
            M_OP:
            begin
                k = op_lookup(sc_held);
                close_token(k >= 0 ? K_OP0 + 7'(k) : K_INVALID, E_NONE);
            end
            M_BCOM, M_BSTAR: close_token(K_INVALID, E_COMMENT);
            default: ;
        endcase
        sc_mode = M_IDLE;
        sc_held = "";
        sc_perr = E_NONE;
    endfunction

    function automatic void open_token(mode_t m);
        sc_mode = m;
        sc_tline = sc_line;
        sc_tcol = sc_col;
        sc_toff = sc_off;
        sc_len = 12'd1;
        sc_perr = E_NONE;
    endfunction

    function automatic void scan_fresh(logic [7:0] c);
        string s;
        if (blank(c)) return;
        s = $sformatf("%c", c);
        if (letter(c)) begin open_token(M_IDENT); sc_kw = s; return; end
        if (c == "0") begin open_token(M_ZERO); return; end
        if (digit(c)) begin open_token(M_DEC); return; end
        if (c == "'") begin open_token(M_CHR); return; end
        if (c == "\"") begin open_token(M_STR); return; end
        if (op_lookup(s) >= 0) begin
            open_token(M_OP);
            sc_held = s;
            if (!op_grows(s)) begin
                close_token(K_OP0 + 7'(op_lookup(s)), E_NONE);
                sc_mode = M_IDLE;
                sc_held = "";
            end
            return;
        end
        open_token(M_IDLE);
        for (int i = 0; i < punct_chars.len(); i++)
            if (punct_chars[i] == c) begin close_token(K_PUNCT0 + 7'(i), E_NONE); return; end
        close_token(K_INVALID, E_CHAR);
    endfunction

    function automatic bit absorb_number(logic [7:0] c);
        bit ok;
        mode_t m;
        m = sc_mode;
        if (c == "." && sc_perr == E_NONE && (m == M_ZERO || m == M_DEC)) begin
            grow_len();
            sc_mode = M_FLOAT;
            return 1;
        end
        if (ends_number(c)) return 0;
        grow_len();
        if (sc_perr != E_NONE) return 1;
        if (m == M_ZERO) begin
            if (c == "x" || c == "X") begin sc_mode = M_HEX; return 1; end
            if (c == "b" || c == "B") begin sc_mode = M_BIN; return 1; end
            sc_mode = M_OCT;
            ok = c >= "0" && c <= "7";
        end
        else if (m == M_OCT) ok = c >= "0" && c <= "7";
        else if (m == M_HEX)
            ok = digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        else if (m == M_BIN) ok = c == "0" || c == "1";
        else ok = digit(c);
        if (!ok) sc_perr = E_DIGIT;
        return 1;
    endfunction

    function automatic bit absorb_op(logic [7:0] c);
        string s;
        int k;
        if (sc_held == "/" && (c == "/" || c == "*")) begin
            grow_len();
            sc_mode = (c == "/") ? M_LCOM : M_BCOM;
            sc_held = "";
            return 1;
        end
        s = $sformatf("%s%c", sc_held, c);
        k = op_lookup(s);
        if (k < 0) return 0;
        grow_len();
        if (op_grows(s)) begin sc_held = s; return 1; end
        close_token(K_OP0 + 7'(k), E_NONE);
        sc_mode = M_IDLE;
        sc_held = "";
        return 1;
    endfunction

    function automatic bit absorb(logic [7:0] c);
        case (sc_mode)
            M_IDENT:
            begin
                if (!letter(c) && !digit(c)) return 0;
                if (sc_len < 8) sc_kw = $sformatf("%s%c", sc_kw, c);
                grow_len();
                return 1;
            end
            M_ZERO, M_DEC, M_OCT, M_HEX, M_BIN, M_FLOAT: return absorb_number(c);
            M_CHR, M_STR:
            begin
                if (c == 8'h0a) return 0;
                grow_len();
                if (c == "\\") sc_mode = (sc_mode == M_CHR) ? M_CHR_ESC : M_STR_ESC;
                else if ((sc_mode == M_CHR && c == "'") || (sc_mode == M_STR && c == "\"")) begin
                    close_token(sc_mode == M_CHR ? K_CHAR : K_STRING, E_NONE);
                    sc_mode = M_IDLE;
                end
                return 1;
            end
            M_CHR_ESC, M_STR_ESC:
            begin
                if (c == 8'h0a) return 0;
                grow_len();
                sc_mode = (sc_mode == M_CHR_ESC) ? M_CHR : M_STR;
                return 1;
            end
            M_OP: return absorb_op(c);
            M_LCOM:
            begin
                if (c == 8'h0a) return 0;
                grow_len();
                return 1;
            end
            M_BCOM, M_BSTAR:
            begin
                grow_len();
                if (c == "*") sc_mode = M_BSTAR;
                else if (c == "/" && sc_mode == M_BSTAR) sc_mode = M_IDLE;
                else sc_mode = M_BCOM;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic void scanner_reset();
        sc_mode = M_IDLE;
        sc_held = "";
        sc_kw = "";
        sc_len = '0;
        sc_tline = 16'd1;
        sc_tcol = 12'd1;
        sc_toff = '0;
        sc_line = 16'd1;
        sc_col = 12'd1;
        sc_off = '0;
        sc_perr = E_NONE;
    endfunction

    // Advance the model by one accepted byte and queue the events it causes.
    function automatic void scan_byte(in_item_t it);
        logic [7:0] c;
        c = it.char_code;
        step_events.delete();
        if (sc_mode == M_DONE) return;
        if (c != 8'h00) begin
            if (!absorb(c)) begin
                flush_token();
                scan_fresh(c);
            end
            if (sc_off != 24'hffffff) sc_off = sc_off + 24'd1;
            if (c == 8'h0a) begin
                if (sc_line != 16'hffff) sc_line = sc_line + 16'd1;
                sc_col = 12'd1;
            end
            else if (sc_col != 12'hfff) sc_col = sc_col + 12'd1;
        end
        if (c == 8'h00 || it.end_of_text) begin
            flush_token();
            add_event(K_END, E_NONE, sc_line, sc_col, sc_off, 12'd0);
            sc_mode = M_DONE;
        end
        if (step_events.size() > 0) step_events[step_events.size() - 1].last_of_run = 1'b1;
        foreach (step_events[i]) token_q = {token_q, step_events[i]};
    endfunction

    // Random C-like text
    byte unsigned src[$];

    function automatic void put_byte(byte unsigned b);
        src = {src, b};
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_random_token();
        string digits;
        int n;
        case ($urandom_range(0, 9))
            0:
            begin
                n = $urandom_range(1, 11);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0: put_byte(byte'($urandom_range("a", "z")));
                        1: put_byte(byte'($urandom_range("A", "Z")));
                        2: put_byte(i == 0 ? "_" : byte'($urandom_range("0", "9")));
                        default: put_byte(i == 0 ? "$" : "e");
                    endcase
                end
            end
            1: put_text(kw_names[$urandom_range(0, 22)]);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: begin put_text("0x"); digits = "0123456789abcdefABCDEFg"; end
                    1: begin put_text("0b"); digits = "0112"; end
                    2: begin put_text("0"); digits = "012345679"; end
                    default: begin put_text("1"); digits = "0123456789a"; end
                endcase
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                    put_byte(digits[$urandom_range(0, digits.len() - 1)]);
                if ($urandom_range(0, 3) == 0) put_text(".5");
            end
            3, 4:
            begin
                digits = ($urandom_range(0, 1) == 0) ? "\"" : "'";
                put_text(digits);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 9))
                        0: put_text("\\n");
                        1: put_text("\\\"");
                        2: put_text("\\'");
                        3: put_byte(8'h0a);
                        default: put_byte(byte'($urandom_range(" ", "~")));
                    endcase
                end
                if ($urandom_range(0, 7) != 0) put_text(digits);
            end
            5:
            begin
                digits = "+-*/%&|!~<>^=";
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    put_byte(digits[$urandom_range(0, digits.len() - 1)]);
            end
            6: put_byte(punct_chars[$urandom_range(0, 9)]);
            7:
            begin
                if ($urandom_range(0, 1)) put_text("// note x*/\n");
                else put_text("/* a * b\n**/");
            end
            8: put_byte(($urandom_range(0, 1) == 0) ? 8'h09 : 8'h0a);
            default: put_byte(byte'($urandom_range(1, 255)));
        endcase
        if ($urandom_range(0, 2) != 0) put_byte(" ");
    endfunction

    row_t rows[23] = '{
        '{"@", 1, K_INVALID, E_CHAR}, '{8'hff, 1, K_INVALID, E_CHAR},
        '{";", 1, K_PUNCT0 + 7'd9, E_NONE},
        '{"0", 0, K_END, E_NONE}, '{"9", 0, K_END, E_NONE}, '{" ", 1, K_OCT, E_DIGIT},
        '{"\"", 0, K_END, E_NONE}, '{8'h0a, 1, K_STRING, E_UNTERM},
        '{"0", 0, K_END, E_NONE}, '{"x", 0, K_END, E_NONE}, '{" ", 1, K_HEX, E_NONE},
        '{">", 0, K_END, E_NONE}, '{">", 0, K_END, E_NONE},
        '{"=", 1, K_OP0 + 7'd29, E_NONE},
        '{"i", 0, K_END, E_NONE}, '{"f", 0, K_END, E_NONE},
        '{" ", 1, K_KEY0 + 7'd13, E_NONE},
        '{"'", 0, K_END, E_NONE}, '{"'", 1, K_CHAR, E_NONE},
        '{"/", 0, K_END, E_NONE}, '{"/", 0, K_END, E_NONE}, '{"c", 0, K_END, E_NONE},
        '{8'h0a, 0, K_END, E_NONE}
    };

    function automatic int idle_gap(bit calm);
        if (calm) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(5, 25);
    endfunction

    // Offer one request and hold it until accepted.
    task automatic send_byte(in_item_t it, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
        scan_byte(it);
    endtask

    initial begin
        in_item_t it;
        bit calm;
        int n;
        scanner_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        calm = 0;
        foreach (rows[i]) begin
            it = '{rows[i].ch, 1'b0};
            send_byte(it, idle_gap(calm));
            if (rows[i].chk) begin
                if (step_events.size() == 0) begin
                    $error("row %0d: no event predicted", i);
                    errors++;
                end
                else if (step_events[0].token_kind != rows[i].kind
                         || step_events[0].error_code != rows[i].err) begin
                    $error("row %0d: kind/error expected %0d/%0d, model %0d/%0d", i,
                           rows[i].kind, rows[i].err, step_events[0].token_kind,
                           step_events[0].error_code);
                    errors++;
                end
            end
        end
        while (src.size() < 250) put_random_token();
        case ($urandom_range(0, 2))
            0: put_text("/* open *");
            1: put_text("\"open\\");
            default: ;
        endcase
        foreach (src[i]) begin
            if ($urandom_range(0, 39) == 0) calm = !calm;
            if (bytes_sent == 120) hold_req = 1;
            it = '{src[i], 1'b0};
            send_byte(it, idle_gap(calm));
        end
        // Close the text with a zero byte or with the end flag on a real byte.
        if ($urandom_range(0, 1)) it = '{8'h00, 1'($urandom_range(0, 1))};
        else it = '{";", 1'b1};
        send_byte(it, idle_gap(0));
        // Bytes after the end are dropped by the scanner.
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            it = '{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))};
            send_byte(it, idle_gap(0));
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver back-pressure, with one long hold while the sender keeps going.
    initial begin
        int stall;
        int hold;
        bit calm;
        stall = 0;
        hold = 0;
        calm = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 0;
                hold = HOLD_CYCLES;
            end
            if ($urandom_range(0, 63) == 0) calm = !calm;
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                stall = idle_gap(calm);
            end
        end
    end

    always @(posedge clk) begin
        out_item_t exp_ev;
        cycles <= cycles + 1;
        if (out_valid && out_ready) begin
            events_seen <= events_seen + 1;
            if (token_q.size() == 0) begin
                $error("unexpected event kind %0d", out_data.token_kind);
                errors++;
            end
            else begin
                exp_ev = token_q.pop_front();
                if (out_data.token_kind !== exp_ev.token_kind) begin
                    $error("token_kind expected %0d actual %0d", exp_ev.token_kind,
                           out_data.token_kind);
                    errors++;
                end
                if (out_data.error_code !== exp_ev.error_code) begin
                    $error("error_code expected %0d actual %0d", exp_ev.error_code,
                           out_data.error_code);
                    errors++;
                end
                if (out_data.start_line !== exp_ev.start_line) begin
                    $error("start_line expected %0d actual %0d", exp_ev.start_line,
                           out_data.start_line);
                    errors++;
                end
                if (out_data.start_column !== exp_ev.start_column) begin
                    $error("start_column expected %0d actual %0d", exp_ev.start_column,
                           out_data.start_column);
                    errors++;
                end
                if (out_data.start_offset !== exp_ev.start_offset) begin
                    $error("start_offset expected %0d actual %0d", exp_ev.start_offset,
                           out_data.start_offset);
                    errors++;
                end
                if (out_data.token_length !== exp_ev.token_length) begin
                    $error("token_length expected %0d actual %0d", exp_ev.token_length,
                           out_data.token_length);
                    errors++;
                end
                if (out_data.last_of_run !== exp_ev.last_of_run) begin
                    $error("last_of_run expected %0d actual %0d", exp_ev.last_of_run,
                           out_data.last_of_run);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done && token_q.size() == 0);
        repeat (20) @(posedge clk);
        $display("Scanned %0d bytes of directed and random C-like text, %0d token events.",
                 bytes_sent, events_seen);
        $display("Text ended by %s; one long receiver hold exercised input stall.",
                 "zero byte or end flag");
        if (errors == 0 && token_q.size() == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("Timeout after %0d cycles.", cycles);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
design/cts_pkg.sv
design/cts_scan_core.sv
design/cts_out_queue.sv
design/c_style_token_scanner.sv
tb/tb_top.sv
